// File: rtl/core/lcpr_pkg.sv
// Shared types and constants for the lamp current PID regulator.
package lcpr_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int BRIGHT_W    = 9;
    localparam int PWM_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int SUM_W       = 16;
    localparam int ERR_W       = 12;
    localparam int DERIV_W     = 13;
    localparam int INTEG_W     = 24;
    localparam int PROD_W      = 40;
    localparam int ACC_W       = 42;
    localparam int NP_W        = ACC_W - 8;
    localparam int DIV_STEPS   = SAMPLE_W + 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [BRIGHT_W-1:0] BRIGHT_THRESHOLD = 9'd244;

    typedef struct packed {
        logic [SAMPLE_W-1:0] current_sample;
        logic [BRIGHT_W-1:0] brightness;
    } sample_t;

    typedef struct packed {
        logic [PWM_W-1:0]    drive_pwm;
        logic [PWM_W-1:0]    full_pwm;
        logic [SAMPLE_W-1:0] average_current;
        logic                regulated;
    } result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic [BRIGHT_W-1:0] bright;
    } job_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] target_current;
        logic [GAIN_W-1:0]   gain_proportional;
        logic [GAIN_W-1:0]   gain_integral;
        logic [GAIN_W-1:0]   gain_derivative;
        logic [PWM_W-1:0]    pwm_floor;
        logic [PWM_W-1:0]    pwm_ceiling;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_current:    10'd512,
        gain_proportional: 16'd0,
        gain_integral:     16'd0,
        gain_derivative:   16'd0,
        pwm_floor:         8'd0,
        pwm_ceiling:       8'd255
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET  = 3'd0,
        CFG_KP      = 3'd1,
        CFG_KI      = 3'd2,
        CFG_KD      = 3'd3,
        CFG_FLOOR   = 3'd4,
        CFG_CEILING = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_TRUNC,
        ST_CLAMP,
        ST_OUT
    } back_state_t;

endpackage

// File: rtl/core/lcpr_front.sv
// Front end: sample accumulation and batch averaging.
module lcpr_front #(
    parameter int SAMPLES_PER_UPDATE = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  lcpr_pkg::sample_t sample,
    input  logic              queue_full,
    output logic              queue_push,
    output lcpr_pkg::job_t    queue_job
);
    import lcpr_pkg::*;

    localparam int COUNT_W = $clog2(SAMPLES_PER_UPDATE + 1);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(SAMPLES_PER_UPDATE - 1);

    // mean by reciprocal multiply, exact for every SUM_W-bit sum
    localparam int     DIV_SHIFT   = SUM_W + $clog2(SAMPLES_PER_UPDATE);
    localparam int     RECIP_W     = SUM_W + 1;
    localparam longint DIV_RECIP_L = ((longint'(1) << DIV_SHIFT)
                                     + longint'(SAMPLES_PER_UPDATE) - 1)
                                     / longint'(SAMPLES_PER_UPDATE);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);

    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W-1:0]         sum_add;
    logic [SUM_W+RECIP_W-1:0] avg_prod;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     accept;
    logic                     batch_done;

    assign sample_stall = queue_full;
    assign accept       = sample_valid && !queue_full;
    assign sum_add      = sum_reg + SUM_W'(sample.current_sample);
    assign batch_done   = accept && (count_reg == COUNT_LAST);
    assign avg_prod     = sum_add * DIV_RECIP;

    assign queue_push       = batch_done;
    assign queue_job.avg    = avg_prod[DIV_SHIFT +: SAMPLE_W];
    assign queue_job.bright = sample.brightness;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (batch_done)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            sum_next   = sum_add;
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/lcpr_queue.sv
// Two-entry job queue between front and back.
module lcpr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lcpr_pkg::job_t wr_job,
    input  logic           pop,
    output logic           rd_valid,
    output lcpr_pkg::job_t rd_job
);
    import lcpr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign full     = (cnt_reg == CNT_FULL);
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/core/lcpr_back.sv
// Back end: brightness divide, PID step, clamp and result register.
module lcpr_back #(
    parameter int INITIAL_PWM = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  lcpr_pkg::job_t    job,
    output logic              job_pop,
    input  lcpr_pkg::cfg_t    cfg,
    output logic              result_valid,
    input  logic              result_stall,
    output lcpr_pkg::result_t result
);
    import lcpr_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [SAMPLE_W-1:0]        avg_reg;
    logic [BRIGHT_W-1:0]        bright_reg;
    logic                       regulated_reg;
    logic [BRIGHT_W-1:0]        rem_reg;
    logic [DIV_STEPS-1:0]       dq_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DERIV_W-1:0]  deriv_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [ERR_W-1:0]    last_err_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [NP_W-1:0]     np_reg;
    logic [PWM_W-1:0]           full_reg;
    logic [PWM_W-1:0]           full_next;
    result_t                    result_reg;
    logic                       result_valid_reg;

    logic                       load_out;
    logic                       job_bright;
    logic [BRIGHT_W:0]          rem_shift;
    logic                       rem_ge;
    logic signed [ERR_W-1:0]    err_new;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [DERIV_W-1:0]  deriv_new;
    logic signed [GAIN_W-1:0]   mul_a;
    logic signed [INTEG_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [NP_W-1:0]     np_new;
    logic signed [NP_W-1:0]     ceil_ext;
    logic signed [NP_W-1:0]     floor_ext;
    logic [PWM_W+BRIGHT_W-1:0]  drive_prod;
    logic [BRIGHT_W-1:0]        drive_hi;
    logic [PWM_W-1:0]           drive;

    assign job_bright = (job.bright >= BRIGHT_THRESHOLD);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job_bright ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:   state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_ACC;
            ST_ACC:   state_next = ST_TRUNC;
            ST_TRUNC: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        job_pop  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: job_pop  = job_valid;
            ST_OUT:  load_out = !result_valid_reg || !result_stall;
            default:
            begin
                job_pop  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // restoring divide step
    assign rem_shift = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, bright_reg});

    // error, integral, derivative
    assign err_new   = $signed({2'b00, cfg.target_current})
                     - $signed({1'b0, dq_reg[SAMPLE_W:0]});
    assign integ_sum = $signed({integ_reg[INTEG_W-1], integ_reg})
                     + $signed({{(INTEG_W + 1 - ERR_W){err_new[ERR_W-1]}}, err_new});
    assign deriv_new = $signed({err_new[ERR_W-1], err_new})
                     - $signed({last_err_reg[ERR_W-1], last_err_reg});

    always_comb
    begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    // shared gain multiplier
    always_comb
    begin
        mul_a = $signed(cfg.gain_proportional);
        mul_b = $signed({{(INTEG_W - ERR_W){err_reg[ERR_W-1]}}, err_reg});
        case (state_reg)
            ST_MUL_I:
            begin
                mul_a = $signed(cfg.gain_integral);
                mul_b = integ_reg;
            end
            ST_MUL_D:
            begin
                mul_a = $signed(cfg.gain_derivative);
                mul_b = $signed({{(INTEG_W - DERIV_W){deriv_reg[DERIV_W-1]}}, deriv_reg});
            end
            default:
            begin
                mul_a = $signed(cfg.gain_proportional);
                mul_b = $signed({{(INTEG_W - ERR_W){err_reg[ERR_W-1]}}, err_reg});
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = $signed({{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    // truncate toward zero
    assign np_new = $signed(acc_reg[ACC_W-1:8])
                  + $signed({{(NP_W-1){1'b0}}, acc_reg[ACC_W-1] && (acc_reg[7:0] != '0)});

    assign ceil_ext  = $signed({{(NP_W - PWM_W){1'b0}}, cfg.pwm_ceiling});
    assign floor_ext = $signed({{(NP_W - PWM_W){1'b0}}, cfg.pwm_floor});

    always_comb
    begin
        full_next = full_reg;
        if (state_reg == ST_CLAMP)
        begin
            if (np_reg > ceil_ext)
            begin
                full_next = cfg.pwm_ceiling;
            end
            else if (np_reg < floor_ext)
            begin
                full_next = cfg.pwm_floor;
            end
            else
            begin
                full_next = np_reg[PWM_W-1:0];
            end
        end
    end

    assign drive_prod = full_reg * bright_reg;
    assign drive_hi   = drive_prod[PWM_W+BRIGHT_W-1:8];
    assign drive      = drive_hi[BRIGHT_W-1] ? {PWM_W{1'b1}} : drive_hi[PWM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            full_reg         <= PWM_W'(INITIAL_PWM);
            integ_reg        <= '0;
            last_err_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            if (state_reg == ST_ERR)
            begin
                integ_reg    <= integ_next;
                last_err_reg <= err_new;
            end
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    avg_reg       <= job.avg;
                    bright_reg    <= job.bright;
                    regulated_reg <= job_bright;
                    dq_reg        <= {job.avg, 8'd0};
                    rem_reg       <= '0;
                    step_reg      <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg  <= rem_ge ? BRIGHT_W'(rem_shift - {1'b0, bright_reg})
                                   : rem_shift[BRIGHT_W-1:0];
                dq_reg   <= {dq_reg[DIV_STEPS-2:0], rem_ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_ERR:
            begin
                err_reg   <= err_new;
                deriv_reg <= deriv_new;
            end
            ST_MUL_P:
            begin
                prod_reg <= mul_p;
                acc_reg  <= $signed({{(ACC_W - PWM_W - 8){1'b0}}, full_reg, 8'd0});
            end
            ST_MUL_I, ST_MUL_D:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_ext;
            end
            ST_ACC:
            begin
                acc_reg <= acc_reg + prod_ext;
            end
            ST_TRUNC:
            begin
                np_reg <= np_new;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    result_reg.drive_pwm       <= drive;
                    result_reg.full_pwm        <= full_reg;
                    result_reg.average_current <= avg_reg;
                    result_reg.regulated       <= regulated_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/lamp_current_pid_regulator.sv
// Top level of the lamp current PID regulator: config registers, front, queue, back.
//
// Samples are taken one per cycle while the job queue has room; every
// SAMPLES_PER_UPDATE samples close a batch whose mean goes to the back end.
// A batch at brightness of 0.95 or more passes through the back end in order:
// take the job from the queue, bit-serial divide by brightness, then error,
// three passes of the shared 16x24 gain multiplier, accumulate, truncate,
// clamp and output load; a batch at lower brightness goes from taking the
// job straight to output load, where a stalled result holds it. The
// two-entry queue lets the front keep collecting while the back end works or
// the result is held.
// Config writes are always ready; write only while no batch is in flight.
module lamp_current_pid_regulator #(
    parameter int SAMPLES_PER_UPDATE = 4,
    parameter int INITIAL_PWM        = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  lcpr_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lcpr_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcpr_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      queue_push;
    logic      queue_full;
    job_t      front_job;
    job_t      head_job;
    logic      head_valid;
    logic      head_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET:  cfg_next.target_current    = cfg_data[SAMPLE_W-1:0];
                CFG_KP:      cfg_next.gain_proportional = cfg_data[GAIN_W-1:0];
                CFG_KI:      cfg_next.gain_integral     = cfg_data[GAIN_W-1:0];
                CFG_KD:      cfg_next.gain_derivative   = cfg_data[GAIN_W-1:0];
                CFG_FLOOR:   cfg_next.pwm_floor         = cfg_data[PWM_W-1:0];
                CFG_CEILING: cfg_next.pwm_ceiling       = cfg_data[PWM_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcpr_front #(
        .SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .queue_full   (queue_full),
        .queue_push   (queue_push),
        .queue_job    (front_job)
    );

    lcpr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .full     (queue_full),
        .wr_job   (front_job),
        .pop      (head_pop),
        .rd_valid (head_valid),
        .rd_job   (head_job)
    );

    lcpr_back #(
        .INITIAL_PWM(INITIAL_PWM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (head_valid),
        .job          (head_job),
        .job_pop      (head_pop),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/core/lcpr_checker.sv
// Port-level assertions for the lamp current PID regulator, with bind.
module lcpr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input lcpr_pkg::result_t result
);
    import lcpr_pkg::*;

    // held request keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // below regulation brightness the drive never exceeds the full PWM
    a_dim_drive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.regulated |-> result.drive_pwm <= result.full_pwm)
        else $error("drive above full PWM on dim batch");

    // no result out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid right after reset");

    // sample stall only comes from a full queue, which fills on an accepted sample
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_stall) |-> $past(sample_valid))
        else $error("sample stall without a preceding request");

endmodule

bind lamp_current_pid_regulator lcpr_checker u_checker (.*);
